// File: src/enfa_pkg.sv
// ----------------------------------------------------------------------------
// enfa_pkg
// Shared constants, types and the control store of the lambda-NFA acceptor.
// ----------------------------------------------------------------------------
`default_nettype none

package enfa_pkg;

   localparam int NUM_STATES    = 16;
   localparam int NUM_SYMBOLS   = 27;
   localparam int LAMBDA_SYM    = NUM_SYMBOLS - 1;
   localparam int NUM_ROWS      = NUM_STATES * NUM_SYMBOLS;
   localparam int ROW_W         = $clog2(NUM_ROWS);
   localparam int STATE_W       = $clog2(NUM_STATES);
   localparam int SYM_W         = $clog2(NUM_SYMBOLS);

   localparam int MODE_W        = 2;
   localparam int FIELD_STATE_W = 4;
   localparam int FIELD_SYM_W   = 5;
   localparam int INIT_W        = 4;
   localparam int MASK_W        = 16;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 16;
   localparam int STEP_W        = 4;

   typedef logic [NUM_STATES-1:0] set_type;
   typedef logic [STEP_W-1:0]     step_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD    = 2'd0,
      MODE_START  = 2'd1,
      MODE_LETTER = 2'd2,
      MODE_END    = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_STATE = 1'b0,
      CSR_FINAL_MASK  = 1'b1
   } csr_idx_type;

   typedef enum logic [3:0] {
      OP_NONE     = 4'd0,
      OP_CLEAR    = 4'd1,
      OP_ADD_RD   = 4'd2,
      OP_ADD_WR   = 4'd3,
      OP_START    = 4'd4,
      OP_LET_INIT = 4'd5,
      OP_SCAN     = 4'd6,
      OP_TAKE_ACC = 4'd7,
      OP_GROW     = 4'd8,
      OP_EMIT     = 4'd9
   } dp_op_type;

   typedef enum logic [2:0] {
      COND_ALWAYS   = 3'd0,
      COND_DISPATCH = 3'd1,
      COND_CLR_MORE = 3'd2,
      COND_S_MORE   = 3'd3,
      COND_ADD_BAD  = 3'd4,
      COND_SYM_BAD  = 3'd5,
      COND_GREW     = 3'd6,
      COND_OUT_FREE = 3'd7
   } cond_type;

   localparam step_type ST_CLEAR    = 4'd0;
   localparam step_type ST_IDLE     = 4'd1;
   localparam step_type ST_ADD_RD   = 4'd2;
   localparam step_type ST_ADD_WR   = 4'd3;
   localparam step_type ST_START    = 4'd4;
   localparam step_type ST_LET      = 4'd5;
   localparam step_type ST_LET_SCAN = 4'd6;
   localparam step_type ST_LET_DRN  = 4'd7;
   localparam step_type ST_LET_DONE = 4'd8;
   localparam step_type ST_CL_SCAN  = 4'd9;
   localparam step_type ST_CL_DRN   = 4'd10;
   localparam step_type ST_CL_TEST  = 4'd11;
   localparam step_type ST_RET      = 4'd12;
   localparam step_type ST_EMIT     = 4'd13;

   typedef struct packed {
      dp_op_type op;
      cond_type  cond;
      step_type  target;
   } ctrl_word_type;

   typedef struct packed {
      logic clr_last;
      logic s_last;
      logic add_bad;
      logic sym_bad;
      logic grew;
      logic out_free;
   } dp_status_type;

   // Control store. A taken condition jumps to target, otherwise step + 1
   // (out_free holds the step instead; dispatch jumps to the entry step of the request's mode, or holds).
   function automatic ctrl_word_type ucode(input step_type step);
      ctrl_word_type w;
      case (step)
         ST_CLEAR:    w = '{op: OP_CLEAR,    cond: COND_CLR_MORE, target: ST_CLEAR};
         ST_IDLE:     w = '{op: OP_NONE,     cond: COND_DISPATCH, target: ST_IDLE};
         ST_ADD_RD:   w = '{op: OP_ADD_RD,   cond: COND_ADD_BAD,  target: ST_IDLE};
         ST_ADD_WR:   w = '{op: OP_ADD_WR,   cond: COND_ALWAYS,   target: ST_IDLE};
         ST_START:    w = '{op: OP_START,    cond: COND_ALWAYS,   target: ST_CL_SCAN};
         ST_LET:      w = '{op: OP_LET_INIT, cond: COND_SYM_BAD,  target: ST_IDLE};
         ST_LET_SCAN: w = '{op: OP_SCAN,     cond: COND_S_MORE,   target: ST_LET_SCAN};
         ST_LET_DRN:  w = '{op: OP_NONE,     cond: COND_ALWAYS,   target: ST_LET_DONE};
         ST_LET_DONE: w = '{op: OP_TAKE_ACC, cond: COND_ALWAYS,   target: ST_CL_SCAN};
         ST_CL_SCAN:  w = '{op: OP_SCAN,     cond: COND_S_MORE,   target: ST_CL_SCAN};
         ST_CL_DRN:   w = '{op: OP_NONE,     cond: COND_ALWAYS,   target: ST_CL_TEST};
         ST_CL_TEST:  w = '{op: OP_GROW,     cond: COND_GREW,     target: ST_CL_SCAN};
         ST_RET:      w = '{op: OP_NONE,     cond: COND_ALWAYS,   target: ST_IDLE};
         ST_EMIT:     w = '{op: OP_EMIT,     cond: COND_OUT_FREE, target: ST_IDLE};
         default:     w = '{op: OP_NONE,     cond: COND_ALWAYS,   target: ST_IDLE};
      endcase
      return w;
   endfunction

   function automatic logic [ROW_W-1:0] row_addr(input logic [STATE_W-1:0] s,
                                                 input logic [SYM_W-1:0]   sym);
      logic [ROW_W-1:0] base;
      base = ROW_W'(ROW_W'(s) * ROW_W'(NUM_SYMBOLS));
      return ROW_W'(base + ROW_W'(sym));
   endfunction

endpackage

`default_nettype wire

// File: src/enfa_ram.sv
// ----------------------------------------------------------------------------
// enfa_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module enfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 432
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: src/enfa_dp.sv
// ----------------------------------------------------------------------------
// enfa_dp
// Datapath: transition table, active set, row accumulator, CSRs, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module enfa_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  enfa_pkg::dp_op_type                 op,
   input  logic                                req_fire,
   input  logic [enfa_pkg::FIELD_STATE_W-1:0]  req_src_state,
   input  logic [enfa_pkg::FIELD_STATE_W-1:0]  req_dst_state,
   input  logic [enfa_pkg::FIELD_SYM_W-1:0]    req_symbol,
   input  logic                                csr_fire,
   input  logic [enfa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [enfa_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic                                rsp_accepted,
   output enfa_pkg::dp_status_type             status
);

   logic [enfa_pkg::FIELD_STATE_W-1:0] src_ff, src_in, dst_ff, dst_in;
   logic [enfa_pkg::FIELD_SYM_W-1:0]   sym_ff, sym_in;
   logic [enfa_pkg::INIT_W-1:0]        init_ff, init_in;
   logic [enfa_pkg::MASK_W-1:0]        mask_ff, mask_in;
   enfa_pkg::set_type                  set_ff, set_in, acc_ff, acc_in;
   logic [enfa_pkg::STATE_W-1:0]       s_ff, s_in, rd_s_ff, rd_s_in;
   logic [enfa_pkg::SYM_W-1:0]         scan_sym_ff, scan_sym_in;
   logic                               rd_vld_ff, rd_vld_in;
   logic [enfa_pkg::ROW_W-1:0]         clr_ff, clr_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_acc_ff, rsp_acc_in;

   logic [enfa_pkg::ROW_W-1:0] ram_addr, add_addr, scan_addr;
   logic                       ram_we;
   enfa_pkg::set_type          ram_wdata, ram_rdata, dst_bit, init_bit;
   logic                       add_bad, sym_bad, init_ok, out_free;

   always_comb begin
      add_bad = !(int'(src_ff) < enfa_pkg::NUM_STATES &&
                  int'(dst_ff) < enfa_pkg::NUM_STATES &&
                  int'(sym_ff) < enfa_pkg::NUM_SYMBOLS);
      sym_bad   = int'(sym_ff) >= enfa_pkg::LAMBDA_SYM;
      init_ok   = int'(init_ff) < enfa_pkg::NUM_STATES;
      dst_bit   = enfa_pkg::set_type'(1) << dst_ff;
      init_bit  = enfa_pkg::set_type'(1) << init_ff;
      add_addr  = enfa_pkg::row_addr(enfa_pkg::STATE_W'(src_ff), enfa_pkg::SYM_W'(sym_ff));
      scan_addr = enfa_pkg::row_addr(s_ff, scan_sym_ff);
      out_free  = !rsp_valid_ff || !rsp_stall;

      status.clr_last = clr_ff == enfa_pkg::ROW_W'(enfa_pkg::NUM_ROWS - 1);
      status.s_last   = s_ff == enfa_pkg::STATE_W'(enfa_pkg::NUM_STATES - 1);
      status.add_bad  = add_bad;
      status.sym_bad  = sym_bad;
      status.grew     = |(acc_ff & ~set_ff);
      status.out_free = out_free;
   end

   always_comb begin
      ram_addr  = scan_addr;
      ram_we    = 1'b0;
      ram_wdata = '0;
      case (op)
         enfa_pkg::OP_CLEAR: begin
            ram_addr = clr_ff;
            ram_we   = 1'b1;
         end
         enfa_pkg::OP_ADD_RD: begin
            ram_addr = add_addr;
         end
         enfa_pkg::OP_ADD_WR: begin
            ram_addr  = add_addr;
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | dst_bit;
         end
         default: begin
            ram_addr = scan_addr;
         end
      endcase
   end

   enfa_ram #(
      .WIDTH (enfa_pkg::NUM_STATES),
      .DEPTH (enfa_pkg::NUM_ROWS)
   ) u_table (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ram_we),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      src_in       = src_ff;
      dst_in       = dst_ff;
      sym_in       = sym_ff;
      init_in      = init_ff;
      mask_in      = mask_ff;
      set_in       = set_ff;
      acc_in       = acc_ff;
      s_in         = s_ff;
      scan_sym_in  = scan_sym_ff;
      clr_in       = clr_ff;
      rd_vld_in    = op == enfa_pkg::OP_SCAN;
      rd_s_in      = s_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_acc_in   = rsp_acc_ff;

      if (req_fire) begin
         src_in = req_src_state;
         dst_in = req_dst_state;
         sym_in = req_symbol;
      end

      if (csr_fire) begin
         case (enfa_pkg::csr_idx_type'(csr_index))
            enfa_pkg::CSR_START_STATE: init_in = enfa_pkg::INIT_W'(csr_data);
            enfa_pkg::CSR_FINAL_MASK:  mask_in = enfa_pkg::MASK_W'(csr_data);
            default: ;
         endcase
      end

      // rows of active states only; read data arrives in the cycle after its scan step
      if (rd_vld_ff && set_ff[rd_s_ff]) begin
         acc_in = acc_ff | ram_rdata;
      end

      case (op)
         enfa_pkg::OP_CLEAR: begin
            clr_in = enfa_pkg::ROW_W'(clr_ff + 1'b1);
         end
         enfa_pkg::OP_START: begin
            set_in      = init_ok ? init_bit : '0;
            acc_in      = '0;
            s_in        = '0;
            scan_sym_in = enfa_pkg::SYM_W'(enfa_pkg::LAMBDA_SYM);
         end
         enfa_pkg::OP_LET_INIT: begin
            if (sym_bad) begin
               set_in = '0;
            end
            acc_in      = '0;
            s_in        = '0;
            scan_sym_in = enfa_pkg::SYM_W'(sym_ff);
         end
         enfa_pkg::OP_SCAN: begin
            s_in = enfa_pkg::STATE_W'(s_ff + 1'b1);
         end
         enfa_pkg::OP_TAKE_ACC: begin
            set_in      = acc_ff;
            acc_in      = '0;
            s_in        = '0;
            scan_sym_in = enfa_pkg::SYM_W'(enfa_pkg::LAMBDA_SYM);
         end
         enfa_pkg::OP_GROW: begin
            set_in = set_ff | acc_ff;
            acc_in = '0;
            s_in   = '0;
         end
         enfa_pkg::OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = |(set_ff & enfa_pkg::set_type'(mask_ff));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff      <= '0;
         mask_ff      <= '0;
         set_ff       <= '0;
         clr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         init_ff      <= init_in;
         mask_ff      <= mask_in;
         set_ff       <= set_in;
         clr_ff       <= clr_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      sym_ff      <= sym_in;
      acc_ff      <= acc_in;
      s_ff        <= s_in;
      rd_s_ff     <= rd_s_in;
      scan_sym_ff <= scan_sym_in;
      rsp_acc_ff  <= rsp_acc_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_acc_ff;

`ifndef SYNTHESIS
   a_table_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (op == enfa_pkg::OP_CLEAR || (op == enfa_pkg::OP_ADD_WR && !add_bad)))
      else $error("table written outside clear or valid add");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(op) == enfa_pkg::OP_EMIT)
      else $error("response raised without emit step");

   a_closure_grows: assert property (@(posedge clock) disable iff (reset)
      op == enfa_pkg::OP_GROW |=> (set_ff & $past(set_ff)) == $past(set_ff))
      else $error("closure step dropped an active state");
`endif

endmodule

`default_nettype wire

// File: src/enfa_seq.sv
// ----------------------------------------------------------------------------
// enfa_seq
// Microcode sequencer: step counter, control store lookup, conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module enfa_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_fire,
   input  logic [enfa_pkg::MODE_W-1:0]   req_mode,
   input  enfa_pkg::dp_status_type       status,
   output enfa_pkg::dp_op_type           op,
   output logic                          idle
);

   enfa_pkg::step_type      pc_ff, pc_in, pc_inc, dispatch;
   enfa_pkg::ctrl_word_type ctrl;
   logic                    taken;

   always_comb begin
      ctrl   = enfa_pkg::ucode(pc_ff);
      pc_inc = enfa_pkg::step_type'(pc_ff + 1'b1);

      case (enfa_pkg::mode_type'(req_mode))
         enfa_pkg::MODE_ADD:    dispatch = enfa_pkg::ST_ADD_RD;
         enfa_pkg::MODE_START:  dispatch = enfa_pkg::ST_START;
         enfa_pkg::MODE_LETTER: dispatch = enfa_pkg::ST_LET;
         enfa_pkg::MODE_END:    dispatch = enfa_pkg::ST_EMIT;
         default:               dispatch = enfa_pkg::ST_IDLE;
      endcase

      case (ctrl.cond)
         enfa_pkg::COND_CLR_MORE: taken = !status.clr_last;
         enfa_pkg::COND_S_MORE:   taken = !status.s_last;
         enfa_pkg::COND_ADD_BAD:  taken = status.add_bad;
         enfa_pkg::COND_SYM_BAD:  taken = status.sym_bad;
         enfa_pkg::COND_GREW:     taken = status.grew;
         default:                 taken = 1'b1;
      endcase

      case (ctrl.cond)
         enfa_pkg::COND_DISPATCH: pc_in = req_fire ? dispatch : pc_ff;
         enfa_pkg::COND_OUT_FREE: pc_in = status.out_free ? ctrl.target : pc_ff;
         default:                 pc_in = taken ? ctrl.target : pc_inc;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= enfa_pkg::ST_CLEAR;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign op   = ctrl.op;
   assign idle = pc_ff == enfa_pkg::ST_IDLE;

endmodule

`default_nettype wire

// File: src/epsilon_nfa_word_acceptor.sv
// ----------------------------------------------------------------------------
// epsilon_nfa_word_acceptor
// Lambda-NFA word acceptor: microcoded sequencer over a transition-table RAM.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  req      in   valid / stall    mode, src_state, dst_state, symbol
//  rsp      out  valid / stall    accepted (one per end-of-word transaction)
//  csr      in   valid / ready    index, data (0 start state, 1 final mask)
//
//  N = 16 states, one table read per cycle; a closure pass scans every state.
//  add reads then writes a row (only reads if out of range); start and letter
//  repeat closure passes while the set grows, at most N-1 times; end emits.
//  After reset the table is cleared, one row a cycle, all 432 rows: req stalls.
//  req stalls while a transaction is in progress; an end transaction waits
//  in place while a previous result is still stalled on rsp.
// ----------------------------------------------------------------------------
`default_nettype none

module epsilon_nfa_word_acceptor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [enfa_pkg::MODE_W-1:0]         req_mode,
   input  logic [enfa_pkg::FIELD_STATE_W-1:0]  req_src_state,
   input  logic [enfa_pkg::FIELD_STATE_W-1:0]  req_dst_state,
   input  logic [enfa_pkg::FIELD_SYM_W-1:0]    req_symbol,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_accepted,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [enfa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [enfa_pkg::CSR_DATA_W-1:0]     csr_data
);

   enfa_pkg::dp_op_type     op;
   enfa_pkg::dp_status_type status;
   logic                    idle, req_fire, csr_fire;

   assign req_stall = !idle;
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   enfa_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_mode (req_mode),
      .status   (status),
      .op       (op),
      .idle     (idle)
   );

   enfa_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .op            (op),
      .req_fire      (req_fire),
      .req_src_state (req_src_state),
      .req_dst_state (req_dst_state),
      .req_symbol    (req_symbol),
      .csr_fire      (csr_fire),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_accepted  (rsp_accepted),
      .status        (status)
   );

endmodule

`default_nettype wire

// File: sim/enfa_word_checker.sv
// ----------------------------------------------------------------------------
// enfa_word_checker
// Watches the req, rsp and csr channels of the lambda-NFA acceptor. It keeps
// its own transition table, active set and registers, predicts the verdict
// of every end-of-word transaction and compares it with the rsp transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module enfa_word_checker
   import enfa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [MODE_W-1:0]        req_mode,
   input  logic [FIELD_STATE_W-1:0] req_src_state,
   input  logic [FIELD_STATE_W-1:0] req_dst_state,
   input  logic [FIELD_SYM_W-1:0]   req_symbol,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic                     rsp_accepted,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data,
   output int                       fail_count,
   output int                       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EXP_DEPTH = 64;

   set_type           trans_rows [NUM_ROWS];
   set_type           active_states;
   logic [INIT_W-1:0] start_state;
   set_type           accept_mask;
   bit                expected_accept [EXP_DEPTH];
   int                exp_wr;
   int                exp_rd;
   bit                want;
   int                mismatches;

   initial begin
      fail_count = 0;
      pending    = 0;
      mismatches = 0;
      exp_wr     = 0;
      exp_rd     = 0;
   end

   // union of the rows of every state in 'from' for one symbol
   function automatic set_type step_targets(input set_type from, input int sym);
      set_type acc;
      acc = '0;
      for (int s = 0; s < NUM_STATES; s++)
         if (from[s]) acc |= trans_rows[s * NUM_SYMBOLS + sym];
      return acc;
   endfunction

   function automatic set_type lambda_closure(input set_type from);
      set_type cur;
      set_type grown;
      cur = from;
      for (int n = 0; n < NUM_STATES; n++) begin
         grown = cur | step_targets(cur, LAMBDA_SYM);
         if (grown == cur) break;
         cur = grown;
      end
      return cur;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_ROWS; r++) trans_rows[r] = '0;
         active_states = '0;
         start_state   = '0;
         accept_mask   = '0;
         exp_wr        = 0;
         exp_rd        = 0;
         mismatches    = 0;
         fail_count   <= 0;
         pending      <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (exp_rd == exp_wr) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected rsp transaction, accepted=%b",
                           $realtime, rsp_accepted);
            end else begin
               want = expected_accept[exp_rd % EXP_DEPTH];
               exp_rd++;
               if (rsp_accepted !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: accepted mismatch, expected %b actual %b",
                              $realtime, want, rsp_accepted);
               end
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_idx_type'(csr_index))
               CSR_START_STATE: start_state = csr_data[INIT_W-1:0];
               CSR_FINAL_MASK:  accept_mask = csr_data[MASK_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            case (mode_type'(req_mode))
               MODE_ADD: begin
                  if (int'(req_src_state) < NUM_STATES && int'(req_dst_state) < NUM_STATES
                      && int'(req_symbol) < NUM_SYMBOLS)
                     trans_rows[int'(req_src_state) * NUM_SYMBOLS
                                + int'(req_symbol)][req_dst_state] = 1'b1;
               end
               MODE_START: begin
                  if (int'(start_state) < NUM_STATES)
                     active_states = lambda_closure(set_type'(1) << start_state);
                  else
                     active_states = '0;
               end
               MODE_LETTER: begin
                  if (int'(req_symbol) < LAMBDA_SYM)
                     active_states = lambda_closure(step_targets(active_states,
                                                                 int'(req_symbol)));
                  else
                     active_states = '0;
               end
               MODE_END: begin
                  expected_accept[exp_wr % EXP_DEPTH] = |(active_states & accept_mask);
                  exp_wr++;
               end
               default: ;
            endcase
         end

         fail_count <= mismatches;
         pending    <= exp_wr - exp_rd;
      end
   end

endmodule

`default_nettype wire

// File: sim/tb_epsilon_nfa_word_acceptor.sv
// ----------------------------------------------------------------------------
// tb_epsilon_nfa_word_acceptor
// Drives the lambda-NFA acceptor with a directed sequence over the field
// extremes and special cases, then random automata and words under several
// register settings and idle patterns. A checker beside the block predicts
// and compares every verdict; this module makes stimulus and gives the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_epsilon_nfa_word_acceptor;
   timeunit 1ns;
   timeprecision 1ps;

   import enfa_pkg::*;

   localparam int SETTLE_CYCLES   = 400;
   localparam int ITEMS_PER_BLOCK = 185;

   logic                     clock;
   logic                     reset         = 1'b1;
   logic                     req_valid     = 1'b0;
   logic                     req_stall;
   logic [MODE_W-1:0]        req_mode      = '0;
   logic [FIELD_STATE_W-1:0] req_src_state = '0;
   logic [FIELD_STATE_W-1:0] req_dst_state = '0;
   logic [FIELD_SYM_W-1:0]   req_symbol    = '0;
   logic                     rsp_valid;
   logic                     rsp_stall     = 1'b0;
   logic                     rsp_accepted;
   logic                     csr_valid     = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index     = '0;
   logic [CSR_DATA_W-1:0]    csr_data      = '0;

   int fail_count;
   int pending;
   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   int sent_items   = 0;

   epsilon_nfa_word_acceptor dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_src_state (req_src_state),
      .req_dst_state (req_dst_state),
      .req_symbol    (req_symbol),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_accepted  (rsp_accepted),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   enfa_word_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_src_state (req_src_state),
      .req_dst_state (req_dst_state),
      .req_symbol    (req_symbol),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_accepted  (rsp_accepted),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("tb_epsilon_nfa_word_acceptor: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
   end

   task automatic send_item(input mode_type m, input logic [3:0] src,
                            input logic [3:0] dst, input logic [4:0] sym);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= m;
      req_src_state <= src;
      req_dst_state <= dst;
      req_symbol    <= sym;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!(m == MODE_ADD && int'(sym) >= NUM_SYMBOLS)) sent_items++;
   endtask

   task automatic pause_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // results drained, then room for a transaction that gives no result
   task automatic drain();
      pause_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [4:0] pick_letter();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return 5'($urandom_range(0, 3));
      if (r < 95) return 5'($urandom_range(0, 25));
      return 5'($urandom_range(26, 31));
   endfunction

   function automatic logic [4:0] pick_edge_sym();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 5'($urandom_range(0, 3));
      if (r < 67) return 5'(LAMBDA_SYM);
      if (r < 95) return 5'($urandom_range(4, 25));
      return 5'($urandom_range(27, 31));
   endfunction

   task automatic add_random_edge();
      send_item(MODE_ADD, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                pick_edge_sym());
   endtask

   task automatic run_word();
      int n;
      n = $urandom_range(0, 6);
      send_item(MODE_START, 4'($urandom), 4'($urandom), 5'($urandom));
      repeat (n) send_item(MODE_LETTER, 4'($urandom), 4'($urandom), pick_letter());
      // some words are left open on purpose
      if ($urandom_range(0, 99) < 90)
         send_item(MODE_END, 4'($urandom), 4'($urandom), 5'($urandom));
   endtask

   task automatic random_block(input int blk);
      logic [15:0] init_data;
      logic [15:0] mask_data;
      int          goal;
      init_data = 16'($urandom);
      case (blk)
         0:       begin init_data[3:0] = 4'd0;  mask_data = 16'($urandom); end
         1:       begin init_data[3:0] = 4'd15; mask_data = 16'hFFFF; end
         2:       mask_data = 16'h0000;
         3:       mask_data = 16'h0001 << $urandom_range(0, 15);
         4:       begin init_data[3:0] = 4'd0;  mask_data = 16'($urandom & $urandom); end
         default: mask_data = 16'($urandom);
      endcase
      drain();
      write_csr(CSR_START_STATE, init_data);
      write_csr(CSR_FINAL_MASK, mask_data);
      goal = sent_items + ITEMS_PER_BLOCK;
      repeat (12) add_random_edge();
      while (sent_items < goal) begin
         if ($urandom_range(0, 99) < 3) pause_for_results();
         if ($urandom_range(0, 99) < 5)
            send_item(mode_type'($urandom_range(0, 3)), 4'($urandom), 4'($urandom),
                      5'($urandom));
         if ($urandom_range(0, 99) < 20) add_random_edge();
         run_word();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // end and letter straight after reset
      send_item(MODE_END,    4'd0, 4'd0, 5'd0);
      send_item(MODE_LETTER, 4'd0, 4'd0, 5'd0);
      send_item(MODE_END,    4'd15, 4'd15, 5'd31);
      drain();
      write_csr(CSR_START_STATE, 16'hFFF0);
      write_csr(CSR_FINAL_MASK, 16'h8000);

      send_item(MODE_ADD, 4'd0,  4'd1,  5'd0);
      send_item(MODE_ADD, 4'd1,  4'd2,  5'd26);
      send_item(MODE_ADD, 4'd2,  4'd15, 5'd26);
      send_item(MODE_ADD, 4'd15, 4'd15, 5'd25);
      send_item(MODE_ADD, 4'd15, 4'd0,  5'd26);
      send_item(MODE_ADD, 4'd0,  4'd1,  5'd0);    // duplicate
      send_item(MODE_ADD, 4'd3,  4'd4,  5'd27);   // symbol out of range
      send_item(MODE_ADD, 4'd15, 4'd15, 5'd31);
      send_item(MODE_START,  4'd0, 4'd0, 5'd0);
      send_item(MODE_END,    4'd0, 4'd0, 5'd0);
      send_item(MODE_LETTER, 4'd0, 4'd0, 5'd0);
      send_item(MODE_END,    4'd0, 4'd0, 5'd0);
      send_item(MODE_LETTER, 4'd0, 4'd0, 5'd25);
      send_item(MODE_END,    4'd0, 4'd0, 5'd0);
      send_item(MODE_LETTER, 4'd0, 4'd0, 5'd26);  // lambda used as a letter
      send_item(MODE_END,    4'd0, 4'd0, 5'd0);
      send_item(MODE_START,  4'd0, 4'd0, 5'd0);
      send_item(MODE_LETTER, 4'd0, 4'd0, 5'd0);
      send_item(MODE_LETTER, 4'd0, 4'd0, 5'd31);
      send_item(MODE_END,    4'd0, 4'd0, 5'd0);
      drain();
      write_csr(CSR_START_STATE, 16'h000F);
      write_csr(CSR_FINAL_MASK, 16'hFFFF);
      send_item(MODE_START, 4'd0, 4'd0, 5'd0);
      send_item(MODE_END,   4'd0, 4'd0, 5'd0);

      snd_idle_pct = 26;
      rcv_idle_pct = 45;
      random_block(0);
      random_block(1);
      snd_idle_pct = 45;
      rcv_idle_pct = 26;
      random_block(2);
      random_block(3);
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      random_block(4);
      random_block(5);

      drain();
      if (fail_count == 0 && pending == 0)
         $display("tb_epsilon_nfa_word_acceptor: PASS");
      else
         $display("tb_epsilon_nfa_word_acceptor: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
